[rtl/pse_pkg.sv]
// shared constants and controller/datapath interface types for the prime sieve engine
`timescale 1ns / 1ps

package pse_pkg;

  localparam int VALUE_W  = 16;  // width of numbers, limit and prime
  localparam int CURSOR_W = 17;  // cursor may sit one past 65535
  localparam int ROW_W    = 16;  // marks held per bitmap row
  localparam int ROW_BITS = 4;   // log2 of ROW_W
  localparam int SQ_W     = 2 * VALUE_W;

  localparam logic [CURSOR_W-1:0] FIRST_CANDIDATE = CURSOR_W'(2);
  localparam logic [VALUE_W-1:0]  LIMIT_RESET     = VALUE_W'(100);

  // commands from controller to datapath
  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic cursor_init;
    logic scan_rd;
    logic scan_chk;
    logic sq_calc;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic out_load;
    logic out_found;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic cur_gt_lim;
    logic scan_hit;
    logic sq_le_lim;
    logic j_le_lim;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/pse_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/pse_ctrl.sv]
// sequencing state machine for clear, scan, square and strike phases
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_restart,
  output logic                in_stall,
  input  pse_pkg::dp_status_t status,
  output pse_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SQ,
    S_MARK_INIT,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE_HIT,
    S_DONE_MISS
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_after_r, scan_after_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    scan_after_nxt = scan_after_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cmd.clr_start   = 1'b1;
            cmd.cursor_init = 1'b1;
            scan_after_nxt  = 1'b1;
            state_nxt       = S_CLEAR;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt      = scan_after_r ? S_SCAN_RD : S_IDLE;
          scan_after_nxt = 1'b0;
        end
      end
      S_SCAN_RD: begin
        if (status.cur_gt_lim) begin
          state_nxt = S_DONE_MISS;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = status.scan_hit ? S_SQ : S_SCAN_RD;
      end
      S_SQ: begin
        cmd.sq_calc = 1'b1;
        state_nxt   = S_MARK_INIT;
      end
      S_MARK_INIT: begin
        if (status.sq_le_lim) begin
          cmd.mark_start = 1'b1;
          state_nxt      = S_MARK_RD;
        end else begin
          state_nxt = S_DONE_HIT;
        end
      end
      S_MARK_RD: begin
        if (status.j_le_lim) begin
          cmd.mark_rd = 1'b1;
          state_nxt   = S_MARK_WR;
        end else begin
          state_nxt = S_DONE_HIT;
        end
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = S_MARK_RD;
      end
      S_DONE_HIT: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DONE_MISS: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      scan_after_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_after_r <= scan_after_nxt;
    end
  end

endmodule

[rtl/pse_dp.sv]
// sieve datapath: limit, cursor, bitmap ram, squaring, strike pointer and result register
`timescale 1ns / 1ps

module pse_dp #(
  parameter int SIEVE_DEPTH = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pse_pkg::VALUE_W-1:0]         cfg_wr_data,
  input  pse_pkg::ctrl_cmd_t                  cmd,
  output pse_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pse_pkg::VALUE_W-1:0]         out_prime_value,
  output logic                                out_found
);

  localparam int VW = pse_pkg::VALUE_W;
  localparam int CW = pse_pkg::CURSOR_W;
  localparam int RW = pse_pkg::ROW_W;
  localparam int RB = pse_pkg::ROW_BITS;
  // numbers are 16 bits, so no more of the bitmap than that is ever reached
  localparam int USED_DEPTH = (SIEVE_DEPTH > (2 ** VW)) ? (2 ** VW) : SIEVE_DEPTH;
  localparam int ROWS = (USED_DEPTH + RW - 1) / RW;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [VW-1:0]  LIM_MAX  = VW'(USED_DEPTH - 1);
  localparam logic [RAW-1:0] ROW_LAST = RAW'(ROWS - 1);

  logic [VW-1:0]              limit_r;
  logic [CW-1:0]              cursor_r;
  logic [VW-1:0]              prime_r;
  logic [pse_pkg::SQ_W-1:0]   sq_r;
  logic [CW-1:0]              j_r;
  logic [RAW-1:0]             clr_row_r;
  logic                       out_valid_r;
  logic [VW-1:0]              out_prime_r;
  logic                       out_found_r;

  logic [VW-1:0]  lim;
  logic           wr_en, rd_en;
  logic [RAW-1:0] wr_addr, rd_addr;
  logic [RW-1:0]  wr_data, rd_data;
  logic [RAW-1:0] cur_row, j_row;
  logic           on_lim_row;
  logic [RW-1:0]  cand;
  logic           hit;
  logic [RB-1:0]  hit_bit;
  logic [VW-1:0]  hit_value;

  assign lim = (limit_r > LIM_MAX) ? LIM_MAX : limit_r;

  assign cur_row    = cursor_r[RB +: RAW];
  assign j_row      = j_r[RB +: RAW];
  assign on_lim_row = (cursor_r[CW-1:RB] == {1'b0, lim[VW-1:RB]});

  // unmarked numbers at or after the cursor and not past the limit in the row just read
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = 0; b < RW; b++) begin
      cand[b] = !rd_data[b] && (RB'(b) >= cursor_r[RB-1:0]) &&
                (!on_lim_row || (RB'(b) <= lim[RB-1:0]));
    end
    for (int b = RW - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_bit = RB'(b);
      end
    end
  end

  assign hit_value = {cursor_r[VW-1:RB], hit_bit};

  // one port clears or writes back a struck row, the other reads for scan or strike
  assign wr_en   = cmd.clr_step || cmd.mark_wr;
  assign wr_addr = cmd.clr_step ? clr_row_r : j_row;
  assign wr_data = cmd.clr_step ? '0 : (rd_data | (RW'(1) << j_r[RB-1:0]));
  assign rd_en   = cmd.scan_rd || cmd.mark_rd;
  assign rd_addr = cmd.mark_rd ? j_row : cur_row;

  pse_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= pse_pkg::LIMIT_RESET;
      cursor_r    <= pse_pkg::FIRST_CANDIDATE;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.clr_start) begin
        clr_row_r <= '0;
      end else if (cmd.clr_step) begin
        clr_row_r <= clr_row_r + RAW'(1);
      end
      if (cmd.cursor_init) begin
        cursor_r <= pse_pkg::FIRST_CANDIDATE;
      end else if (cmd.scan_chk) begin
        if (hit) begin
          cursor_r <= CW'(hit_value) + CW'(1);
        end else if (on_lim_row) begin
          // limit row examined in full, cursor rests one past the limit
          cursor_r <= CW'(lim) + CW'(1);
        end else begin
          cursor_r <= {cursor_r[CW-1:RB] + (CW - RB)'(1), RB'(0)};
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_chk && hit) begin
      prime_r <= hit_value;
    end
    if (cmd.sq_calc) begin
      sq_r <= pse_pkg::SQ_W'(prime_r) * pse_pkg::SQ_W'(prime_r);
    end
    // square is known to be within the limit here, so it fits the pointer
    if (cmd.mark_start) begin
      j_r <= sq_r[CW-1:0];
    end else if (cmd.mark_wr) begin
      j_r <= j_r + CW'(prime_r);
    end
    if (cmd.out_load) begin
      out_prime_r <= cmd.out_found ? prime_r : '0;
      out_found_r <= cmd.out_found;
    end
  end

  assign status.clr_last   = (clr_row_r == ROW_LAST);
  assign status.cur_gt_lim = (cursor_r > CW'(lim));
  assign status.scan_hit   = hit;
  assign status.sq_le_lim  = (sq_r <= pse_pkg::SQ_W'(lim));
  assign status.j_le_lim   = (j_r <= CW'(lim));
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_prime_r;
  assign out_found       = out_found_r;

endmodule

[rtl/prime_sieve_engine.sv]
// top level of the prime sieve engine
//
//   port group   dir   handshake            payload
//   cfg_         in    cfg_wr_en            cfg_wr_data (upper limit)
//   in_          in    in_valid / in_stall  in_restart
//   out_         out   out_valid/out_stall  out_prime_value, out_found
//
// one request at a time; scan reads and checks each 16-number bitmap row from the cursor,
// then the prime is squared and each multiple struck by read-modify-write on the single
// bitmap ram until the strike pointer passes the limit; exhaustion is found by the limit
// check; either way the result register is loaded last
// restart adds a clearing pass over ceil(min(SIEVE_DEPTH,65536)/16) rows, and the same
// pass runs after reset with in_stall high; cfg writes are taken at any time
// a result waiting under out_stall holds the engine in its final state until taken
`timescale 1ns / 1ps

module prime_sieve_engine #(
  parameter int SIEVE_DEPTH = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pse_pkg::VALUE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pse_pkg::VALUE_W-1:0] out_prime_value,
  output logic                        out_found
);

  pse_pkg::ctrl_cmd_t  cmd;
  pse_pkg::dp_status_t status;

  pse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  pse_dp #(
    .SIEVE_DEPTH (SIEVE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prime_value (out_prime_value),
    .out_found       (out_found)
  );

endmodule

[rtl/pse_checker.sv]
// port-level checks on the prime sieve engine, bound to its top level
`timescale 1ns / 1ps

module pse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pse_pkg::VALUE_W-1:0] out_prime_value,
  input logic                        out_found
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_value) && $stable(out_found))
    else $error("result changed while stalled");

  // exhaustion reports a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_prime_value == '0)
    else $error("exhausted result carries a value");

  // a found prime is never 0 or 1
  a_hit_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_prime_value > pse_pkg::VALUE_W'(1))
    else $error("found prime below 2");

  // the bitmap clear after reset keeps the input closed
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // a transfer in starts work, so the next item must wait
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer accepted back to back");

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_prime_value (out_prime_value),
  .out_found       (out_found)
);
